### rtl/pitch_scale_quantizer_core_assert.svh
// Assertion macros shared by the pitch scale quantizer RTL.
`ifndef PITCH_SCALE_QUANTIZER_CORE_ASSERT_SVH
`define PITCH_SCALE_QUANTIZER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define PSQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pitch scale quantizer assertion failed");

// Clocked assertion that also holds during reset.
`define PSQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("pitch scale quantizer assertion failed");

`endif

### rtl/psq_pkg.sv
// Shared types and constants for the pitch scale quantizer.
package psq_pkg;

    localparam int FUNC_W    = 2;
    localparam int PITCH_W   = 15;
    localparam int ENTRIES_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_QUERY  = 2'd3
    } t_func;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### rtl/pitch_scale_quantizer_core.sv
// Top level of the pitch scale quantizer: sorted pitch table, sequencer and memory.
//
// The block holds a sorted, duplicate-free table of pitches in a single-port-read,
// single-port-write memory of TABLE_DEPTH entries and walks it with a small
// sequencer, at most one memory access per cycle. An item is taken when start is high and
// busy is low; busy then stays high until the result, which appears on the o_
// result ports for exactly one cycle with o_valid high and cannot be held off.
// A single add scans up to the insert point, then shifts the entries above it up
// one place with a read and a write per entry; a periodic add first works out
// pitch mod step in the shared W-bit remainder unit (W = max(15, 7+FRAC_BITS))
// and then repeats the single insert for every occurrence below 128. A remove
// reads each entry once and, for a periodic remove, passes each entry at or above
// the base through the same remainder unit.
// No clearing pass follows reset: the table is sized by its fill count.
`include "pitch_scale_quantizer_core_assert.svh"

module pitch_scale_quantizer_core #(
    parameter int TABLE_DEPTH = 128,
    parameter int FRAC_BITS   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [psq_pkg::FUNC_W-1:0]     i_func,
    input  logic [psq_pkg::PITCH_W-1:0]    i_pitch,
    input  logic [psq_pkg::PITCH_W-1:0]    i_step,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [psq_pkg::PITCH_W-1:0]    o_nearest,
    output logic [psq_pkg::ENTRIES_W-1:0]  o_entries,
    output logic                           o_empty_res,
    output logic                           o_overflow
);
    import psq_pkg::*;

    localparam int LIM_SH = 7 + FRAC_BITS;
    localparam int EW     = (LIM_SH > PITCH_W) ? LIM_SH : PITCH_W;
    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam logic [EW:0] PITCH_LIMIT = (EW+1)'(1) << LIM_SH;

    typedef enum logic [3:0] {
        S_IDLE, S_BASE, S_INS_CHK, S_INS_RD, S_INS_CMP, S_INS_PLACE,
        S_SH_RD, S_SH_WR, S_INS_NEXT, S_RM_RD, S_RM_CMP, S_RM_DIV,
        S_Q_RD, S_Q_CMP, S_FIN
    } t_state;

    t_state          r_state;
    t_func           r_func;
    logic            r_single;
    logic [EW-1:0]   r_pitch;
    logic [PITCH_W-1:0] r_step;
    logic [EW-1:0]   r_base;
    logic [EW:0]     r_v;
    logic [EW-1:0]   r_e;
    logic [EW-1:0]   r_lo;
    logic [EW-1:0]   r_near;
    logic            r_found;
    logic            r_ovf;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_wr;
    logic [CW-1:0]   r_k;
    logic [CW-1:0]   r_pos;

    logic [EW-1:0]   r_mem [TABLE_DEPTH];
    logic [EW-1:0]   r_rdata;
    logic            mem_re;
    logic            mem_we;
    logic [AW-1:0]   mem_raddr;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;

    logic            div_start;
    logic [EW-1:0]   div_dividend;
    t_div_stat       div_stat;
    logic [PITCH_W-1:0] div_rem;

    logic            accept;
    logic [EW-1:0]   d_lo;
    logic [EW-1:0]   d_hi;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign d_lo   = r_pitch - r_lo;
    assign d_hi   = r_rdata - r_pitch;

    psq_div #(.DW(EW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (accept ? i_step : r_step),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    // Memory and remainder unit control.
    always_comb begin
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_raddr    = r_idx[AW-1:0];
        mem_waddr    = r_wr[AW-1:0];
        mem_wdata    = r_rdata;
        div_start    = 1'b0;
        div_dividend = EW'(i_pitch);
        unique case (r_state)
            S_IDLE: begin
                div_start = accept && (i_step != '0)
                         && ((t_func'(i_func) == FUNC_ADD) || (t_func'(i_func) == FUNC_REMOVE));
            end
            S_INS_RD, S_RM_RD, S_Q_RD: begin
                mem_re = (r_idx != r_count);
            end
            S_SH_RD: begin
                if (r_k == r_pos) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = r_v[EW-1:0];
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_k - 1'b1);
                end
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
            end
            S_RM_CMP: begin
                if (r_single) begin
                    mem_we = (r_rdata != r_base);
                end else if (r_rdata < r_base) begin
                    mem_we = 1'b1;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = r_rdata - r_base;
                end
            end
            S_RM_DIV: begin
                mem_we    = div_stat.done && (div_rem != '0);
                mem_wdata = r_e;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func   <= t_func'(i_func);
                        r_single <= (i_step == '0);
                        r_pitch  <= EW'(i_pitch);
                        r_step   <= i_step;
                        r_found  <= 1'b0;
                        // a query on an empty table echoes the pitch
                        r_near   <= ((t_func'(i_func) == FUNC_QUERY) && (r_count == '0))
                                  ? EW'(i_pitch) : '0;
                        r_ovf    <= 1'b0;
                        r_idx    <= '0;
                        r_wr     <= '0;
                        unique case (t_func'(i_func))
                            FUNC_ADD: begin
                                if (i_step == '0) begin
                                    r_v     <= (EW+1)'(i_pitch);
                                    r_state <= S_INS_RD;
                                end else begin
                                    r_state <= S_BASE;
                                end
                            end
                            FUNC_REMOVE: begin
                                if (i_step == '0) begin
                                    r_base  <= EW'(i_pitch);
                                    r_state <= S_RM_RD;
                                end else begin
                                    r_state <= S_BASE;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FIN;
                            end
                            FUNC_QUERY: begin
                                if (r_count == '0) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_Q_RD;
                                end
                            end
                        endcase
                    end
                end
                S_BASE: begin
                    if (div_stat.done) begin
                        r_base <= EW'(div_rem);
                        r_v    <= (EW+1)'(div_rem);
                        if (r_func == FUNC_ADD) begin
                            r_state <= S_INS_CHK;
                        end else begin
                            r_state <= S_RM_RD;
                        end
                    end
                end
                S_INS_CHK: begin
                    r_idx <= '0;
                    if (r_v >= PITCH_LIMIT) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    if (r_idx == r_count) begin
                        r_pos   <= r_count;
                        r_state <= S_INS_PLACE;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    priority if ((EW+1)'(r_rdata) < r_v) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_INS_RD;
                    end else if ((EW+1)'(r_rdata) == r_v) begin
                        r_state <= S_INS_NEXT;
                    end else begin
                        r_pos   <= r_idx;
                        r_state <= S_INS_PLACE;
                    end
                end
                S_INS_PLACE: begin
                    if (r_count >= CW'(TABLE_DEPTH)) begin
                        // drop the new pitch, table is full
                        r_ovf   <= 1'b1;
                        r_state <= S_INS_NEXT;
                    end else begin
                        r_k     <= r_count;
                        r_state <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    if (r_k == r_pos) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_INS_NEXT;
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_k     <= r_k - 1'b1;
                    r_state <= S_SH_RD;
                end
                S_INS_NEXT: begin
                    if (r_single) begin
                        r_state <= S_FIN;
                    end else begin
                        r_v     <= r_v + (EW+1)'(r_step);
                        r_state <= S_INS_CHK;
                    end
                end
                S_RM_RD: begin
                    if (r_idx == r_count) begin
                        r_count <= r_wr;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RM_CMP;
                    end
                end
                S_RM_CMP: begin
                    r_e <= r_rdata;
                    if (r_single || (r_rdata < r_base)) begin
                        if (mem_we) begin
                            r_wr <= r_wr + 1'b1;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RM_RD;
                    end else begin
                        r_state <= S_RM_DIV;
                    end
                end
                S_RM_DIV: begin
                    if (div_stat.done) begin
                        // keep the entry unless it lies on the grid
                        if (div_rem != '0) begin
                            r_wr <= r_wr + 1'b1;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RM_RD;
                    end
                end
                S_Q_RD: begin
                    if (r_idx == r_count) begin
                        r_near  <= r_lo;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_Q_CMP;
                    end
                end
                S_Q_CMP: begin
                    priority if (r_rdata < r_pitch) begin
                        r_lo    <= r_rdata;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_Q_RD;
                    end else if (r_rdata == r_pitch) begin
                        r_found <= 1'b1;
                        r_near  <= r_pitch;
                        r_state <= S_FIN;
                    end else if (r_idx == '0) begin
                        r_near  <= r_rdata;
                        r_state <= S_FIN;
                    end else begin
                        r_near  <= (d_lo < d_hi) ? r_lo : r_rdata;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_valid     <= 1'b1;
                    o_found     <= r_found;
                    o_nearest   <= r_near[PITCH_W-1:0];
                    o_entries   <= ENTRIES_W'(r_count);
                    o_empty_res <= (r_count == '0);
                    o_overflow  <= r_ovf;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PSQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH))
    `PSQ_ASSERT(a_valid_from_fin, i_clk, i_rst_n, o_valid |-> $past(r_state == S_FIN))
    `PSQ_ASSERT(a_accept_busy, i_clk, i_rst_n, accept |=> busy)
    `PSQ_ASSERT(a_ovf_only_add, i_clk, i_rst_n, (o_valid && o_overflow) |-> (r_func == FUNC_ADD))
    `PSQ_ASSERT_ALWAYS(a_idle_no_div, i_clk, (r_state == S_IDLE) |-> !div_stat.busy)

endmodule

### rtl/psq_div.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
`include "pitch_scale_quantizer_core_assert.svh"

module psq_div #(
    parameter int DW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DW-1:0]                i_dividend,
    input  logic [psq_pkg::PITCH_W-1:0]  i_divisor,
    output psq_pkg::t_div_stat           o_stat,
    output logic [psq_pkg::PITCH_W-1:0]  o_rem
);
    import psq_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [PITCH_W-1:0] r_rem;
    logic [PITCH_W-1:0] r_d;
    logic [DW-1:0]      r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [PITCH_W:0]   n_trial;

    always_comb begin
        n_trial = {r_rem, r_q[DW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                // shift in the next bit, subtract when it fits
                if (n_trial >= {1'b0, r_d}) begin
                    r_rem <= PITCH_W'(n_trial - {1'b0, r_d});
                end else begin
                    r_rem <= n_trial[PITCH_W-1:0];
                end
                r_q   <= r_q << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

    `PSQ_ASSERT(a_div_done_not_busy, i_clk, i_rst_n, r_done |-> !r_busy)
    `PSQ_ASSERT(a_div_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `PSQ_ASSERT(a_div_cnt_bound, i_clk, i_rst_n, r_busy |-> (r_cnt != '0))

endmodule
